@@ design/pot_sample_plausibility_check_defines.svh @@
// ----------------------------------------------------------------------------
// pot_sample_plausibility_check_defines
// Assertion macros shared by the potentiometer sample checker; they
// compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POT_SAMPLE_PLAUSIBILITY_CHECK_DEFINES_SVH
`define POT_SAMPLE_PLAUSIBILITY_CHECK_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PSPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen out of reset
`define PSPC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PSPC_ASSERT(lbl, prop, msg)
`define PSPC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ design/pspc_pkg.sv @@
// ----------------------------------------------------------------------------
// pspc_pkg
// Types and constants of the potentiometer sample plausibility checker.
// ----------------------------------------------------------------------------
package pspc_pkg;

  // converter and checker constants
  localparam logic [11:0] FULL_SCALE = 12'd4095;
  localparam logic [11:0] DISC_LOW   = 12'd1;
  localparam logic [11:0] DISC_HIGH  = 12'd4094;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  // serial multiplier geometry
  localparam int MUL_A_W   = 20;
  localparam int MUL_B_W   = 13;
  localparam int MUL_P_W   = 34;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // serial divider geometry
  localparam int DIV_N_W   = 34;
  localparam int DIV_D_W   = 12;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_READY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_HIGH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VREF         = 3'd7;

  typedef struct packed {
    logic               sensor_ready;
    logic [11:0]        jump_limit;
    logic [15:0]        stuck_limit;
    logic [11:0]        cal_low_count;
    logic [11:0]        cal_high_count;
    logic signed [18:0] angle_low_mdeg;
    logic signed [18:0] angle_high_mdeg;
    logic [12:0]        vref_mv;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sensor_ready:    1'b0,
    jump_limit:      12'd128,
    stuck_limit:     16'd50,
    cal_low_count:   12'd0,
    cal_high_count:  12'd4095,
    angle_low_mdeg:  19'sd0,
    angle_high_mdeg: 19'sd180000,
    vref_mv:         13'd3300
  };

  // input word
  typedef struct packed {
    logic [11:0] adc_value;
    logic        conv_failed;
    logic [31:0] now_ms;
  } in_t;

  // result word
  typedef struct packed {
    logic [11:0]        sample_value;
    logic [12:0]        millivolts;
    logic signed [31:0] angle_mdeg;
    logic [31:0]        stamp_ms;
    logic [31:0]        age_ms;
    logic               flag_not_ready;
    logic               flag_timeout;
    logic               flag_disconnect;
    logic               flag_out_of_range;
    logic               flag_jump;
    logic               flag_stuck;
  } out_t;

  // check stage result
  typedef struct packed {
    logic [11:0] sample_value;
    logic [31:0] age_ms;
    logic        flag_not_ready;
    logic        flag_timeout;
    logic        flag_disconnect;
    logic        flag_out_of_range;
    logic        flag_jump;
    logic        flag_stuck;
  } chk_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_WRITE
  } st_t;

endpackage

@@ design/pot_sample_plausibility_check.sv @@
// Each accepted word runs through three bit-serial multiplies in parallel and
// then two bit-serial divides in parallel; a new word is taken only once the
// last result has been written to the output register, and that write waits
// while the register still holds a stalled result. A finished result waits in
// the output register while the next word is taken. Reset (rst_n low,
// synchronous): configuration registers to defaults, history cleared.
// ----------------------------------------------------------------------------
// pot_sample_plausibility_check
// Potentiometer sample plausibility check with millivolt and angle mapping.
// ----------------------------------------------------------------------------
`include "pot_sample_plausibility_check_defines.svh"

module pot_sample_plausibility_check (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pspc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pspc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pspc_pkg::in_t                       in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pspc_pkg::out_t                      out_word
);
  import pspc_pkg::*;

  cfg_t cfg_r;
  st_t  state_r, state_nxt;
  out_t res_r, res_nxt;
  out_t out_r, out_nxt;
  logic out_valid_r;
  logic signed [MUL_P_W-1:0] num_r;

  chk_t chk;
  logic in_accept;
  logic out_free;
  logic mul_start;
  logic div_start;
  logic out_load;

  logic signed [MUL_A_W-1:0] op_vref;
  logic signed [MUL_A_W-1:0] op_alow;
  logic signed [MUL_A_W-1:0] op_span;
  logic signed [MUL_B_W-1:0] op_value;
  logic signed [MUL_B_W-1:0] op_den;
  logic signed [MUL_B_W-1:0] op_delta;
  logic [11:0]               den;
  logic signed [MUL_P_W-1:0] prod_mv;
  logic signed [MUL_P_W-1:0] prod_low;
  logic signed [MUL_P_W-1:0] prod_span;
  logic                      mul_done_mv;
  logic                      mul_done_low;
  logic                      mul_done_span;
  logic                      mul_done;
  logic [DIV_N_W-1:0]        num_mag;
  logic [DIV_N_W-1:0]        quo_mv;
  logic [DIV_N_W-1:0]        quo_ang;
  logic                      div_done_mv;
  logic                      div_done_ang;
  logic                      div_done;
  logic                      degen;
  logic signed [31:0]        angle;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SENSOR_READY: cfg_r.sensor_ready    <= cfg_data[0];
        REG_JUMP_LIMIT:   cfg_r.jump_limit      <= cfg_data[11:0];
        REG_STUCK_LIMIT:  cfg_r.stuck_limit     <= cfg_data[15:0];
        REG_CAL_LOW:      cfg_r.cal_low_count   <= cfg_data[11:0];
        REG_CAL_HIGH:     cfg_r.cal_high_count  <= cfg_data[11:0];
        REG_ANGLE_LOW:    cfg_r.angle_low_mdeg  <= $signed(cfg_data[18:0]);
        REG_ANGLE_HIGH:   cfg_r.angle_high_mdeg <= $signed(cfg_data[18:0]);
        REG_VREF:         cfg_r.vref_mv         <= cfg_data[12:0];
      endcase
    end
  end

  // flags and history
  pspc_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_word (in_word),
    .cfg     (cfg_r),
    .chk     (chk)
  );

  // multiplier operands
  always_comb begin
    den      = cfg_r.cal_high_count - cfg_r.cal_low_count;
    op_vref  = MUL_A_W'({1'b0, cfg_r.vref_mv});
    op_alow  = MUL_A_W'(cfg_r.angle_low_mdeg);
    op_span  = MUL_A_W'(cfg_r.angle_high_mdeg) - MUL_A_W'(cfg_r.angle_low_mdeg);
    op_value = $signed({1'b0, res_r.sample_value});
    op_den   = $signed({1'b0, den});
    op_delta = $signed({1'b0, res_r.sample_value}) - $signed({1'b0, cfg_r.cal_low_count});
  end

  pspc_mul u_mul_mv (
    .clk (clk), .rst_n (rst_n), .start (mul_start),
    .a (op_vref), .b (op_value), .prod (prod_mv), .done (mul_done_mv)
  );

  pspc_mul u_mul_low (
    .clk (clk), .rst_n (rst_n), .start (mul_start),
    .a (op_alow), .b (op_den), .prod (prod_low), .done (mul_done_low)
  );

  pspc_mul u_mul_span (
    .clk (clk), .rst_n (rst_n), .start (mul_start),
    .a (op_span), .b (op_delta), .prod (prod_span), .done (mul_done_span)
  );

  assign mul_done = mul_done_mv && mul_done_low && mul_done_span;

  // numerator of the angle map and its magnitude
  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      num_r <= prod_low + prod_span;
    end
  end

  assign num_mag = num_r[MUL_P_W-1] ? DIV_N_W'(-num_r) : DIV_N_W'(num_r);

  pspc_div u_div_mv (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .dividend (DIV_N_W'(prod_mv)), .divisor (FULL_SCALE),
    .quotient (quo_mv), .done (div_done_mv)
  );

  pspc_div u_div_ang (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .dividend (num_mag), .divisor (den),
    .quotient (quo_ang), .done (div_done_ang)
  );

  assign div_done = div_done_mv && div_done_ang;

  // signed angle, truncated toward zero; flat or inverted calibration gives the low angle
  always_comb begin
    degen = (cfg_r.cal_high_count <= cfg_r.cal_low_count);
    if (degen) begin
      angle = 32'(cfg_r.angle_low_mdeg);
    end else if (num_r[MUL_P_W-1]) begin
      angle = -$signed(quo_ang[31:0]);
    end else begin
      angle = $signed(quo_ang[31:0]);
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_accept) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_MUL;
      ST_MUL:   if (mul_done) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_WRITE;
      ST_WRITE: if (out_free) state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    mul_start = (state_r == ST_LOAD);
    div_start = (state_r == ST_START);
    out_load  = (state_r == ST_WRITE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // check results held while the arithmetic runs
  always_comb begin
    res_nxt                   = '0;
    res_nxt.sample_value      = chk.sample_value;
    res_nxt.stamp_ms          = in_word.now_ms;
    res_nxt.age_ms            = chk.age_ms;
    res_nxt.flag_not_ready    = chk.flag_not_ready;
    res_nxt.flag_timeout      = chk.flag_timeout;
    res_nxt.flag_disconnect   = chk.flag_disconnect;
    res_nxt.flag_out_of_range = chk.flag_out_of_range;
    res_nxt.flag_jump         = chk.flag_jump;
    res_nxt.flag_stuck        = chk.flag_stuck;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  // output register
  always_comb begin
    out_nxt            = res_r;
    out_nxt.millivolts = quo_mv[12:0];
    out_nxt.angle_mdeg = angle;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // checks
  `PSPC_ASSERT(a_out_from_write, $rose(out_valid_r) |-> $past(state_r == ST_WRITE), "result word raised outside write state")
  `PSPC_ASSERT_NEVER(a_mul_done_state, mul_done_mv && (state_r != ST_MUL), "multiplier finished outside multiply state")
  `PSPC_ASSERT_NEVER(a_div_done_state, div_done_ang && (state_r != ST_DIV), "divider finished outside divide state")
  `PSPC_ASSERT_NEVER(a_div_lockstep, div_done_mv != div_done_ang, "dividers out of step")
  `PSPC_ASSERT(a_timeout_flags, (out_valid_r && out_r.flag_timeout) |-> !(out_r.flag_disconnect || out_r.flag_out_of_range || out_r.flag_jump || out_r.flag_stuck), "check flags set on failed conversion")

endmodule

@@ design/pspc_check.sv @@
// ----------------------------------------------------------------------------
// pspc_check
// Plausibility flags and sample history: last value, repeat counter and
// time of the last good sample.
// ----------------------------------------------------------------------------
module pspc_check (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  pspc_pkg::in_t  in_word,
  input  pspc_pkg::cfg_t cfg,
  output pspc_pkg::chk_t chk
);
  import pspc_pkg::*;

  logic [11:0] last_value_r, last_value_nxt;
  logic [15:0] repeat_count_r, repeat_count_nxt;
  logic [31:0] last_good_ms_r, last_good_ms_nxt;

  logic [11:0] value;
  logic [11:0] diff;
  logic        same;
  logic        disc;
  logic [15:0] count_inc;
  logic        failed;

  // value in use and distance to the previous one
  always_comb begin
    failed = in_word.conv_failed;
    value  = failed ? last_value_r : in_word.adc_value;
    diff   = (value >= last_value_r) ? value - last_value_r : last_value_r - value;
    same   = (value == last_value_r);
    disc   = (value <= DISC_LOW) || (value >= DISC_HIGH);
    count_inc = (repeat_count_r != COUNT_MAX) ? repeat_count_r + 16'd1 : repeat_count_r;
  end

  // flags; disconnect, range, jump and stuck are gated off on a failed conversion
  always_comb begin
    chk.sample_value      = value;
    chk.age_ms            = failed ? in_word.now_ms - last_good_ms_r : 32'd0;
    chk.flag_not_ready    = !cfg.sensor_ready;
    chk.flag_timeout      = failed;
    chk.flag_disconnect   = !failed && disc;
    chk.flag_out_of_range = !failed && !disc &&
                            ((value < cfg.cal_low_count) || (value > cfg.cal_high_count));
    chk.flag_jump         = !failed && (diff > cfg.jump_limit);
    chk.flag_stuck        = !failed && same && (count_inc >= cfg.stuck_limit);
  end

  // history update on a good sample
  always_comb begin
    last_value_nxt   = last_value_r;
    repeat_count_nxt = repeat_count_r;
    last_good_ms_nxt = last_good_ms_r;
    if (accept && !failed) begin
      last_value_nxt   = value;
      repeat_count_nxt = same ? count_inc : 16'd0;
      last_good_ms_nxt = in_word.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_value_r   <= '0;
      repeat_count_r <= '0;
      last_good_ms_r <= '0;
    end else begin
      last_value_r   <= last_value_nxt;
      repeat_count_r <= repeat_count_nxt;
      last_good_ms_r <= last_good_ms_nxt;
    end
  end

endmodule

@@ design/pspc_mul.sv @@
// ----------------------------------------------------------------------------
// pspc_mul
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle;
// the sign bit of the multiplier carries negative weight.
// ----------------------------------------------------------------------------
module pspc_mul (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic signed [pspc_pkg::MUL_A_W-1:0]      a,
  input  logic signed [pspc_pkg::MUL_B_W-1:0]      b,
  output logic signed [pspc_pkg::MUL_P_W-1:0]      prod,
  output logic                                     done
);
  import pspc_pkg::*;

  logic signed [MUL_P_W-1:0] acc_r, acc_nxt;
  logic signed [MUL_P_W-1:0] a_sh_r, a_sh_nxt;
  logic [MUL_B_W-1:0]        b_sh_r, b_sh_nxt;
  logic [MUL_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic                      last;

  assign last = (cnt_r == MUL_CNT_W'(MUL_B_W - 1));

  // one partial product per cycle
  always_comb begin
    acc_nxt  = acc_r;
    a_sh_nxt = a_sh_r;
    b_sh_nxt = b_sh_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_sh_nxt = MUL_P_W'(a);
      b_sh_nxt = b;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (b_sh_r[0]) begin
        acc_nxt = last ? acc_r - a_sh_r : acc_r + a_sh_r;
      end
      a_sh_nxt = a_sh_r <<< 1;
      b_sh_nxt = b_sh_r >> 1;
      cnt_nxt  = cnt_r + MUL_CNT_W'(1);
      if (last) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    a_sh_r <= a_sh_nxt;
    b_sh_r <= b_sh_nxt;
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

@@ design/pspc_div.sv @@
// ----------------------------------------------------------------------------
// pspc_div
// Bit-serial restoring divider, one quotient bit per cycle; the dividend
// shifts out at the top while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module pspc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [pspc_pkg::DIV_N_W-1:0]      dividend,
  input  logic [pspc_pkg::DIV_D_W-1:0]      divisor,
  output logic [pspc_pkg::DIV_N_W-1:0]      quotient,
  output logic                              done
);
  import pspc_pkg::*;

  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     trial_sub;
  logic                 fits;
  logic                 last;

  // partial remainder with the next dividend bit brought down
  assign trial     = {rem_r, quo_r[DIV_N_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign fits      = (trial >= {1'b0, dvs_r});
  assign last      = (cnt_r == DIV_CNT_W'(DIV_N_W - 1));

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = fits ? trial_sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quo_nxt = {quo_r[DIV_N_W-2:0], fits};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (last) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
